FILE: design/bpsf_pkg.sv
`timescale 1ns / 1ps
package bpsf_pkg;

    localparam int NEEDLE_MAX    = 16;
    localparam int POSITION_BITS = 32;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_FIELD_W = 5;
    localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
    localparam int NIDX_W     = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int WIN_D      = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [WORD_W-1:0]        COUNT_MAX = '1;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW      = 3'd0,
        CFG_NEEDLE_HIGH     = 3'd1,
        CFG_NEEDLE_LENGTH   = 3'd2,
        CFG_FOLD_ENABLE     = 3'd3,
        CFG_SEARCH_BACKWARD = 3'd4,
        CFG_WRAP_ENABLE     = 3'd5,
        CFG_START_OFFSET    = 3'd6,
        CFG_QUERY_OFFSET    = 3'd7
    } t_cfg_idx;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        if (en && (b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
            return b - CH_UPPER_A + CH_LOWER_A;
        end
        return b;
    endfunction

endpackage

FILE: design/bpsf_in_if.sv
`timescale 1ns / 1ps
interface bpsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: design/bpsf_out_if.sv
`timescale 1ns / 1ps
interface bpsf_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;
    logic [31:0] match_count;
    logic [31:0] query_ordinal;

    modport source (output valid, output found, output match_position,
                    output match_count, output query_ordinal, input ready);
    modport sink   (input valid, input found, input match_position,
                    input match_count, input query_ordinal, output ready);
endinterface

FILE: design/byte_pattern_search_fold_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Handshake
// i_in      in   data_byte[7:0], last_byte                        valid/ready
// o_res     out  found, match_position, match_count, query_ordinal valid/ready
// i_cfg_*   in   i_cfg_index[2:0], i_cfg_data[63:0]               i_cfg_we
//
// One byte per cycle sustained. An item is held in the input register,
// then the window compare and match bookkeeping update the state registers;
// the result register loads in that same cycle for a last byte.
// Synchronous active-low reset clears configuration, stream state and valids.
// A last byte stalls in the input register only while a previous result waits.
module byte_pattern_search_fold_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bpsf_in_if.sink                             i_in,
    bpsf_out_if.source                          o_res
);
    import bpsf_pkg::*;

    logic [CFG_DATA_W-1:0]  r_needle_lo;
    logic [CFG_DATA_W-1:0]  r_needle_hi;
    logic [LEN_FIELD_W-1:0] r_len;
    logic                   r_fold;
    logic                   r_back;
    logic                   r_wrap;
    logic [WORD_W-1:0]      r_start;
    logic [WORD_W-1:0]      r_query;

    logic               r_iv;
    logic [BYTE_W-1:0]  r_ib;
    logic               r_il;

    logic [WIN_D-1:0][BYTE_W-1:0] r_win;
    logic [POSITION_BITS-1:0]     r_pos;
    logic [WORD_W-1:0] r_total, r_mbq;
    logic              r_qhit;
    logic [WORD_W-1:0] r_fa_pos, r_fs_pos, r_lb_pos, r_la_pos;
    logic              r_fa_seen, r_fs_seen, r_lb_seen, r_la_seen;

    logic              r_ov;
    logic              r_found;
    logic [WORD_W-1:0] r_mpos, r_count, r_ord;

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] w_needle;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] w_hay;
    logic [LEN_W-1:0]         w_len;
    logic [POSITION_BITS-1:0] w_lenm1;
    logic [WORD_W-1:0]        w_s;
    logic                     w_cmp;
    logic                     w_go;
    logic                     w_hit;

    logic [POSITION_BITS-1:0] n_pos;
    logic [WORD_W-1:0] n_total, n_mbq;
    logic              n_qhit;
    logic [WORD_W-1:0] n_fa_pos, n_fs_pos, n_lb_pos, n_la_pos;
    logic              n_fa_seen, n_fs_seen, n_lb_seen, n_la_seen;
    logic              n_found;
    logic [WORD_W-1:0] n_mpos, n_ord;

    assign w_go       = r_iv && (!r_il || !r_ov || o_res.ready);
    assign i_in.ready = !r_iv || w_go;

    assign w_len   = (r_len > LEN_FIELD_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                        : r_len[LEN_W-1:0];
    assign w_lenm1 = POSITION_BITS'(w_len) - POSITION_BITS'(1);
    assign w_s     = WORD_W'(r_pos - w_lenm1);

    always_comb begin
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            w_needle[i] = (i < 8) ? r_needle_lo[(i % 8) * BYTE_W +: BYTE_W]
                                  : r_needle_hi[(i % 8) * BYTE_W +: BYTE_W];
        end
        w_hay[0] = r_ib;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            w_hay[k] = r_win[k-1];
        end
    end

    always_comb begin
        logic [LEN_W-1:0] v_sel;
        w_cmp = (w_len != '0) && (r_pos >= w_lenm1);
        for (int d = 0; d < NEEDLE_MAX; d++) begin
            v_sel = w_len - LEN_W'(d) - LEN_W'(1);
            if (LEN_W'(d) < w_len) begin
                if (fold_byte(w_hay[d], r_fold) !=
                    fold_byte(w_needle[v_sel[NIDX_W-1:0]], r_fold)) begin
                    w_cmp = 1'b0;
                end
            end
        end
    end

    assign w_hit = w_cmp;

    always_comb begin
        n_pos     = (r_pos != POS_MAX) ? r_pos + POSITION_BITS'(1) : r_pos;
        n_total   = r_total;
        n_mbq     = r_mbq;
        n_qhit    = r_qhit;
        n_fa_pos  = r_fa_pos;
        n_fa_seen = r_fa_seen;
        n_fs_pos  = r_fs_pos;
        n_fs_seen = r_fs_seen;
        n_lb_pos  = r_lb_pos;
        n_lb_seen = r_lb_seen;
        n_la_pos  = w_hit ? w_s : r_la_pos;
        n_la_seen = r_la_seen || w_hit;
        if (w_hit) begin
            if (r_total != COUNT_MAX) begin
                n_total = r_total + WORD_W'(1);
            end
            if (!r_fa_seen) begin
                n_fa_seen = 1'b1;
                n_fa_pos  = w_s;
            end
            if ((w_s >= r_start) && !r_fs_seen) begin
                n_fs_seen = 1'b1;
                n_fs_pos  = w_s;
            end
            if (w_s < r_start) begin
                n_lb_seen = 1'b1;
                n_lb_pos  = w_s;
            end
            if ((w_s < r_query) && (r_mbq != COUNT_MAX)) begin
                n_mbq = r_mbq + WORD_W'(1);
            end
            if (w_s == r_query) begin
                n_qhit = 1'b1;
            end
        end

        n_found = 1'b0;
        n_mpos  = '0;
        if (!r_back) begin
            if (n_fs_seen) begin
                n_found = 1'b1;
                n_mpos  = n_fs_pos;
            end else if (r_wrap && n_fa_seen) begin
                n_found = 1'b1;
                n_mpos  = n_fa_pos;
            end
        end else begin
            if (n_lb_seen) begin
                n_found = 1'b1;
                n_mpos  = n_lb_pos;
            end else if (r_wrap && n_la_seen) begin
                n_found = 1'b1;
                n_mpos  = n_la_pos;
            end
        end
        n_ord = '0;
        if (n_qhit) begin
            n_ord = (n_mbq != COUNT_MAX) ? n_mbq + WORD_W'(1) : COUNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_lo <= '0;
            r_needle_hi <= '0;
            r_len       <= '0;
            r_fold      <= 1'b0;
            r_back      <= 1'b0;
            r_wrap      <= 1'b0;
            r_start     <= '0;
            r_query     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NEEDLE_LOW:      r_needle_lo <= i_cfg_data;
                CFG_NEEDLE_HIGH:     r_needle_hi <= i_cfg_data;
                CFG_NEEDLE_LENGTH:   r_len       <= i_cfg_data[LEN_FIELD_W-1:0];
                CFG_FOLD_ENABLE:     r_fold      <= i_cfg_data[0];
                CFG_SEARCH_BACKWARD: r_back      <= i_cfg_data[0];
                CFG_WRAP_ENABLE:     r_wrap      <= i_cfg_data[0];
                CFG_START_OFFSET:    r_start     <= i_cfg_data[WORD_W-1:0];
                CFG_QUERY_OFFSET:    r_query     <= i_cfg_data[WORD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.ready) begin
            r_iv <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ib <= i_in.data_byte;
            r_il <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_win[0] <= r_ib;
            for (int k = 1; k < WIN_D; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_go && r_il)) begin
            r_pos     <= '0;
            r_total   <= '0;
            r_mbq     <= '0;
            r_qhit    <= 1'b0;
            r_fa_pos  <= '0;
            r_fa_seen <= 1'b0;
            r_fs_pos  <= '0;
            r_fs_seen <= 1'b0;
            r_lb_pos  <= '0;
            r_lb_seen <= 1'b0;
            r_la_pos  <= '0;
            r_la_seen <= 1'b0;
        end else if (w_go) begin
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_mbq     <= n_mbq;
            r_qhit    <= n_qhit;
            r_fa_pos  <= n_fa_pos;
            r_fa_seen <= n_fa_seen;
            r_fs_pos  <= n_fs_pos;
            r_fs_seen <= n_fs_seen;
            r_lb_pos  <= n_lb_pos;
            r_lb_seen <= n_lb_seen;
            r_la_pos  <= n_la_pos;
            r_la_seen <= n_la_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_go && r_il) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_il) begin
            r_found <= n_found;
            r_mpos  <= n_mpos;
            r_count <= n_total;
            r_ord   <= n_ord;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.found          = r_found;
    assign o_res.match_position = r_mpos;
    assign o_res.match_count    = r_count;
    assign o_res.query_ordinal  = r_ord;

endmodule

FILE: design/bpsf_checker.sv
`timescale 1ns / 1ps
module bpsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [31:0] i_match_position,
    input logic [31:0] i_match_count,
    input logic [31:0] i_query_ordinal
);
    a_pos_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_match_position == 32'd0))
        else $error("match_position nonzero without a match");

    a_found_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> (i_match_count != 32'd0))
        else $error("found with zero match_count");

    a_ordinal_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_query_ordinal <= i_match_count))
        else $error("query_ordinal exceeds match_count");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result item dropped while stalled");

endmodule

bind byte_pattern_search_fold_top bpsf_checker u_bpsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_found          (o_res.found),
    .i_match_position (o_res.match_position),
    .i_match_count    (o_res.match_count),
    .i_query_ordinal  (o_res.query_ordinal)
);

FILE: sim/tb_byte_pattern_search_fold_top.sv
`timescale 1ns / 1ps
module tb_byte_pattern_search_fold_top;
    import bpsf_pkg::*;

    typedef struct packed {
        logic        found;
        logic [31:0] position;
        logic [31:0] count;
        logic [31:0] ordinal;
    } search_result_t;

    typedef struct {
        logic [63:0] needle_lo;
        logic [63:0] needle_hi;
        logic [4:0]  needle_len;
        logic        fold;
        logic        backward;
        logic        wrap;
        logic [31:0] start;
        logic [31:0] query;
    } search_setup_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bpsf_in_if  in_ch ();
    bpsf_out_if res_ch ();

    byte_pattern_search_fold_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // search state mirrored from the block
    logic [127:0] m_needle;
    logic [4:0]   m_len;
    logic         m_fold;
    logic         m_back;
    logic         m_wrap;
    logic [31:0]  m_start;
    logic [31:0]  m_query;
    logic [7:0]   m_hist [NEEDLE_MAX-1];
    logic [31:0]  m_pos;
    logic [31:0]  m_total;
    logic [31:0]  m_below_query;
    logic         m_query_hit;
    logic [31:0]  m_first_any, m_first_after, m_last_before, m_last_any;
    logic         m_first_any_ok, m_first_after_ok, m_last_before_ok, m_last_any_ok;

    search_result_t pending_results[$];
    logic [7:0]     hay[$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int results_checked;
    int bytes_sent;
    int haystacks_sent;
    int setups_loaded;

    function automatic logic [7:0] fold_char(input logic [7:0] b);
        return (m_fold && b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | 8'h20) : b;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= 8'h7A)) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic int unsigned used_len();
        return (m_len > NEEDLE_MAX) ? NEEDLE_MAX : m_len;
    endfunction

    function automatic void clear_scan();
        foreach (m_hist[i]) m_hist[i] = '0;
        m_pos            = '0;
        m_total          = '0;
        m_below_query    = '0;
        m_query_hit      = 1'b0;
        m_first_any      = '0;
        m_first_after    = '0;
        m_last_before    = '0;
        m_last_any       = '0;
        m_first_any_ok   = 1'b0;
        m_first_after_ok = 1'b0;
        m_last_before_ok = 1'b0;
        m_last_any_ok    = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] cur, input logic last);
        int unsigned    len;
        int unsigned    d;
        logic [31:0]    s;
        logic [7:0]     h;
        logic           hit;
        search_result_t r;
        len = used_len();
        if (len > 0 && m_pos >= len - 1) begin
            s   = m_pos - (len - 1);
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                d = len - 1 - i;
                h = (d == 0) ? cur : m_hist[d - 1];
                if (fold_char(h) != fold_char(m_needle[8*i +: 8])) hit = 1'b0;
            end
            if (hit) begin
                if (m_total != COUNT_MAX) m_total++;
                if (!m_first_any_ok) begin
                    m_first_any_ok = 1'b1;
                    m_first_any    = s;
                end
                m_last_any_ok = 1'b1;
                m_last_any    = s;
                if (s >= m_start && !m_first_after_ok) begin
                    m_first_after_ok = 1'b1;
                    m_first_after    = s;
                end
                if (s < m_start) begin
                    m_last_before_ok = 1'b1;
                    m_last_before    = s;
                end
                if (s < m_query && m_below_query != COUNT_MAX) m_below_query++;
                if (s == m_query) m_query_hit = 1'b1;
            end
        end
        for (int i = NEEDLE_MAX - 2; i > 0; i--) m_hist[i] = m_hist[i - 1];
        m_hist[0] = cur;
        if (m_pos != POS_MAX) m_pos++;
        if (last) begin
            r = '0;
            if (!m_back) begin
                if (m_first_after_ok) begin
                    r.found    = 1'b1;
                    r.position = m_first_after;
                end else if (m_wrap && m_first_any_ok) begin
                    r.found    = 1'b1;
                    r.position = m_first_any;
                end
            end else begin
                if (m_last_before_ok) begin
                    r.found    = 1'b1;
                    r.position = m_last_before;
                end else if (m_wrap && m_last_any_ok) begin
                    r.found    = 1'b1;
                    r.position = m_last_any;
                end
            end
            r.count = m_total;
            if (m_query_hit) begin
                r.ordinal = (m_below_query != COUNT_MAX) ? m_below_query + 1 : COUNT_MAX;
            end
            pending_results.push_back(r);
            clear_scan();
        end
    endfunction

    function automatic void report_error(input string msg);
        if (error_count < 10) $display("%s", msg);
        error_count++;
    endfunction

    function automatic void check_result();
        search_result_t want;
        search_result_t got;
        got = {res_ch.found, res_ch.match_position, res_ch.match_count, res_ch.query_ordinal};
        if (pending_results.size() == 0) begin
            report_error($sformatf("unexpected result: found=%0b pos=%0d count=%0d ord=%0d",
                                   got.found, got.position, got.count, got.ordinal));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.found !== want.found || got.position !== want.position ||
            got.count !== want.count || got.ordinal !== want.ordinal) begin
            report_error($sformatf({"result %0d mismatch: ",
                                    "want found=%0b pos=%0d count=%0d ord=%0d, ",
                                    "got found=%0b pos=%0d count=%0d ord=%0d"},
                results_checked, want.found, want.position, want.count, want.ordinal,
                got.found, got.position, got.count, got.ordinal));
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.last_byte);
            if (res_ch.valid && res_ch.ready) check_result();
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_haystack();
        foreach (hay[i]) send_item(hay[i], i == hay.size() - 1);
        haystacks_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_NEEDLE_LOW:      m_needle[63:0]   = val;
            CFG_NEEDLE_HIGH:     m_needle[127:64] = val;
            CFG_NEEDLE_LENGTH:   m_len            = val[4:0];
            CFG_FOLD_ENABLE:     m_fold           = val[0];
            CFG_SEARCH_BACKWARD: m_back           = val[0];
            CFG_WRAP_ENABLE:     m_wrap           = val[0];
            CFG_START_OFFSET:    m_start          = val[31:0];
            CFG_QUERY_OFFSET:    m_query          = val[31:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_setup(input search_setup_t s);
        wait_idle();
        write_reg(CFG_NEEDLE_LOW, s.needle_lo);
        write_reg(CFG_NEEDLE_HIGH, s.needle_hi);
        write_reg(CFG_NEEDLE_LENGTH, 64'(s.needle_len));
        write_reg(CFG_FOLD_ENABLE, 64'(s.fold));
        write_reg(CFG_SEARCH_BACKWARD, 64'(s.backward));
        write_reg(CFG_WRAP_ENABLE, 64'(s.wrap));
        write_reg(CFG_START_OFFSET, 64'(s.start));
        write_reg(CFG_QUERY_OFFSET, 64'(s.query));
        i_cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    function automatic search_setup_t make_setup(
        input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len,
        input logic fold, input logic backward, input logic wrap,
        input logic [31:0] start, input logic [31:0] query);
        search_setup_t s;
        s.needle_lo  = lo;
        s.needle_hi  = hi;
        s.needle_len = len;
        s.fold       = fold;
        s.backward   = backward;
        s.wrap       = wrap;
        s.start      = start;
        s.query      = query;
        return s;
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(3))
            0:       return CH_LOWER_A;
            1:       return CH_UPPER_A;
            2:       return CH_LOWER_A + 8'd1;
            default: return CH_UPPER_A + 8'd1;
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 15) return '1;
        if (r < 20) return $urandom;
        return $urandom_range(24);
    endfunction

    function automatic search_setup_t random_setup();
        search_setup_t s;
        int unsigned   r;
        logic [127:0]  pat;
        r = $urandom_range(99);
        if (r < 5) s.needle_len = '0;
        else if (r < 10) s.needle_len = 5'($urandom_range(31, 17));
        else if (r < 25) s.needle_len = 5'($urandom_range(16, 5));
        else s.needle_len = 5'($urandom_range(4, 1));
        pat = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            if ($urandom_range(3) != 0) pat[8*i +: 8] = pick_letter();
        end
        s.needle_lo = pat[63:0];
        s.needle_hi = pat[127:64];
        s.fold      = 1'($urandom_range(1));
        s.backward  = 1'($urandom_range(1));
        s.wrap      = 1'($urandom_range(1));
        s.start     = pick_offset();
        s.query     = pick_offset();
        return s;
    endfunction

    // random fill seeded with needle bytes, then planted copies of the needle
    function automatic void build_haystack();
        int unsigned len;
        int unsigned n;
        int unsigned r;
        int unsigned at;
        logic [7:0]  b;
        len = used_len();
        n   = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(24, 1);
        hay.delete();
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45 && len > 0) begin
                b = m_needle[8*$urandom_range(len - 1) +: 8];
                if ($urandom_range(1)) b = flip_case(b);
            end else if (r < 85) begin
                b = pick_letter();
            end else begin
                b = 8'($urandom_range(255));
            end
            hay.push_back(b);
        end
        if (len > 0 && n >= len && $urandom_range(99) < 70) begin
            repeat ($urandom_range(2, 1)) begin
                at = $urandom_range(n - len);
                for (int i = 0; i < len; i++) begin
                    b = m_needle[8*i +: 8];
                    hay[at + i] = (m_fold && $urandom_range(1)) ? flip_case(b) : b;
                end
            end
        end
    endfunction

    task automatic test_unusable_needle();
        load_setup(make_setup(64'h61, '1, 5'd0, 1'b0, 1'b0, 1'b1, '0, '0));
        hay = '{8'h61};
        send_haystack();
    endtask

    task automatic test_case_folding();
        // needle "Ab" against "aBAb", exact then folded
        load_setup(make_setup(64'h6241, '1, 5'd2, 1'b0, 1'b0, 1'b0, 32'd1, 32'd2));
        hay = '{8'h61, 8'h42, 8'h41, 8'h62};
        send_haystack();
        load_setup(make_setup(64'h6241, '1, 5'd2, 1'b1, 1'b0, 1'b0, 32'd1, 32'd2));
        send_haystack();
    endtask

    task automatic test_backward_wrap();
        load_setup(make_setup(64'h61, '0, 5'd1, 1'b0, 1'b1, 1'b0, '0, '0));
        hay = '{8'h61, 8'h61};
        send_haystack();
        load_setup(make_setup(64'h61, '0, 5'd1, 1'b0, 1'b1, 1'b1, '0, '0));
        send_haystack();
        load_setup(make_setup(64'h61, '0, 5'd1, 1'b1, 1'b1, 1'b0, '1, '1));
        hay = '{8'h61, 8'h41};
        send_haystack();
    endtask

    task automatic test_full_needle_clamp();
        // length field above the maximum, letter boundaries around the fold range
        load_setup(make_setup(64'hFF00_4142_617A_5B40, 64'h8000_7F20_5A61_0001, 5'd31,
                              1'b1, 1'b0, 1'b1, '1, '0));
        hay.delete();
        for (int i = 0; i < NEEDLE_MAX; i++) hay.push_back(flip_case(m_needle[8*i +: 8]));
        send_haystack();
    endtask

    task automatic test_random_haystacks(input int byte_budget);
        int first_byte;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < byte_budget) begin
            load_setup(random_setup());
            repeat ($urandom_range(6, 2)) begin
                build_haystack();
                send_haystack();
            end
        end
    endtask

    initial begin
        #(2_000_000);
        $display("tb_byte_pattern_search_fold_top: errors");
        $finish;
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        send_idle_pct   = 28;
        recv_idle_pct   = 64;
        m_needle = '0;
        m_len    = '0;
        m_fold   = 1'b0;
        m_back   = 1'b0;
        m_wrap   = 1'b0;
        m_start  = '0;
        m_query  = '0;
        clear_scan();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_unusable_needle();
        test_case_folding();
        test_backward_wrap();
        test_full_needle_clamp();
        test_random_haystacks(270);
        send_idle_pct = 64;
        recv_idle_pct = 28;
        test_random_haystacks(270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_haystacks(270);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("%0d bytes in %0d haystacks under %0d register setups",
                 bytes_sent, haystacks_sent, setups_loaded);
        $display("%0d results checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("tb_byte_pattern_search_fold_top: clean");
        end else begin
            $display("tb_byte_pattern_search_fold_top: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/bpsf_pkg.sv
design/bpsf_in_if.sv
design/bpsf_out_if.sv
design/byte_pattern_search_fold_top.sv
design/bpsf_checker.sv
sim/tb_byte_pattern_search_fold_top.sv
